### hdl/size_class_free_list_allocator_defines.svh
// ----------------------------------------------------------------------------
// Allocator assertion macros
// Shared property wrappers for the size-class allocator checks.
// ----------------------------------------------------------------------------
`ifndef SIZE_CLASS_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define SIZE_CLASS_FREE_LIST_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define SCFA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator check failed");
`define SCFA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator check failed");
`else
`define SCFA_ASSERT_IMP(lbl, ante, cons)
`define SCFA_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### hdl/scfa_pkg.sv
// ----------------------------------------------------------------------------
// Allocator package
// Size class table, status codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none
package scfa_pkg;

	localparam int NUM_TABLE = 64;

	localparam logic [16:0] CLASS_BYTES [NUM_TABLE] = '{
		17'd2, 17'd4, 17'd8, 17'd16, 17'd32, 17'd64,
		17'd80, 17'd96, 17'd112, 17'd128, 17'd160, 17'd192, 17'd224, 17'd256,
		17'd320, 17'd384, 17'd448, 17'd512, 17'd640, 17'd768, 17'd896, 17'd1024,
		17'd1152, 17'd1280, 17'd1408, 17'd1536, 17'd1664, 17'd1792, 17'd1920, 17'd2048,
		17'd2304, 17'd2560, 17'd2816, 17'd3072, 17'd3328, 17'd3584, 17'd3840, 17'd4096,
		17'd4608, 17'd5120, 17'd5632, 17'd6144, 17'd6656, 17'd7168, 17'd7680, 17'd8192,
		17'd9216, 17'd10240, 17'd11264, 17'd12288, 17'd13312, 17'd14336, 17'd15360,
		17'd16384, 17'd18432, 17'd20480, 17'd22528, 17'd24576, 17'd28672, 17'd32768,
		17'd40960, 17'd49152, 17'd57344, 17'd65536
	};

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_ZERO      = 3'd1;
	localparam logic [2:0] ST_LARGE     = 3'd2;
	localparam logic [2:0] ST_EXHAUSTED = 3'd3;
	localparam logic [2:0] ST_BADFREE   = 3'd4;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef struct packed {
		logic       capture;
		logic       search;
		logic [2:0] step_bit;
		logic       decide;
		logic       pop;
		logic       mul;
	} cmd_t;

	typedef struct packed {
		logic need_pop;
	} stat_t;

endpackage
`default_nettype wire

### hdl/size_class_free_list_allocator.sv
// ----------------------------------------------------------------------------
// Size-class free-list allocator
// Segregated slab allocator: alloc/free requests against per-class pages.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each request runs
// these steps up to the next acceptance: six steps walk the size class
// search, then the head/high-water memories are read, an allocate that
// pops a freed block adds a read of the next-link memory, and a last step
// forms the payload offset. The result word
// appears for one cycle with done high, in the cycle busy falls; the
// receiver cannot stall it, so it must capture the word on that edge.
`default_nettype none
`include "size_class_free_list_allocator_defines.svh"
module size_class_free_list_allocator import scfa_pkg::*; #(
	parameter int PAGE_BYTES   = 65536,
	parameter int HEADER_BYTES = 16,
	parameter int NUM_CLASSES  = 64,
	parameter int MAX_BLOCKS   = 4096
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire         req_type,
	input  wire  [31:0] request_size,
	input  wire  [5:0]  free_class,
	input  wire  [11:0] free_block,
	output logic        done,
	output logic [2:0]  status,
	output logic [5:0]  granted_class,
	output logic [11:0] granted_block,
	output logic [16:0] payload_offset
);

	cmd_t  cmd;
	stat_t stat;

	scfa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .stat(stat),
		.cmd(cmd), .busy(busy), .done(done)
	);

	scfa_dp #(
		.PAGE_BYTES(PAGE_BYTES), .HEADER_BYTES(HEADER_BYTES),
		.NUM_CLASSES(NUM_CLASSES), .MAX_BLOCKS(MAX_BLOCKS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.req_type(req_type), .request_size(request_size),
		.free_class(free_class), .free_block(free_block),
		.status(status), .granted_class(granted_class),
		.granted_block(granted_block), .payload_offset(payload_offset)
	);

	`SCFA_ASSERT_IMP(a_done_idle, done, !busy)
	`SCFA_ASSERT_NXT(a_accept_busy, start && !busy, busy && !done)
	`SCFA_ASSERT_IMP(a_err_no_off, done && (status != ST_OK), payload_offset == 17'd0)
	`SCFA_ASSERT_IMP(a_status_range, done, status <= ST_BADFREE)

endmodule
`default_nettype wire

### hdl/scfa_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module scfa_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 64
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### hdl/scfa_ctrl.sv
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences class search, metadata read, decision, list pop and offset.
// ----------------------------------------------------------------------------
`default_nettype none
module scfa_ctrl import scfa_pkg::*; (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   start,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  busy,
	output logic  done
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_READ,
		S_DECIDE,
		S_POP,
		S_MUL
	} state_t;

	state_t     state_q;
	logic [2:0] step_q;
	logic       busy_q;
	logic       done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= 3'd0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_SEARCH;
						step_q  <= 3'd5;
						busy_q  <= 1'b1;
					end
				end
				S_SEARCH: begin
					if (step_q == 3'd0) begin
						state_q <= S_READ;
					end else begin
						step_q <= step_q - 3'd1;
					end
				end
				S_READ:   state_q <= S_DECIDE;
				S_DECIDE: state_q <= stat.need_pop ? S_POP : S_MUL;
				S_POP:    state_q <= S_MUL;
				S_MUL: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.capture  = (state_q == S_IDLE) && start;
		cmd.search   = (state_q == S_SEARCH);
		cmd.step_bit = step_q;
		cmd.decide   = (state_q == S_DECIDE);
		cmd.pop      = (state_q == S_POP);
		cmd.mul      = (state_q == S_MUL);
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule
`default_nettype wire

### hdl/scfa_dp.sv
// ----------------------------------------------------------------------------
// Allocator datapath
// Request registers, class search, page/list metadata and offset multiply.
// ----------------------------------------------------------------------------
`default_nettype none
module scfa_dp import scfa_pkg::*; #(
	parameter int PAGE_BYTES   = 65536,
	parameter int HEADER_BYTES = 16,
	parameter int NUM_CLASSES  = 64,
	parameter int MAX_BLOCKS   = 4096
) (
	input  wire          clk,
	input  wire          arst_n,
	input  cmd_t         cmd,
	output stat_t        stat,
	input  wire          req_type,
	input  wire  [31:0]  request_size,
	input  wire  [5:0]   free_class,
	input  wire  [11:0]  free_block,
	output logic [2:0]   status,
	output logic [5:0]   granted_class,
	output logic [11:0]  granted_block,
	output logic [16:0]  payload_offset
);

	localparam int CLS_W  = $clog2(NUM_CLASSES);
	localparam int BLK_W  = $clog2(MAX_BLOCKS);
	localparam int LINK_W = BLK_W + 1;
	localparam int HW_W   = $clog2(MAX_BLOCKS + 1);
	localparam int LNK_D  = NUM_CLASSES * (2 ** BLK_W);

	// per-class block count, worked out at elaboration
	logic [HW_W-1:0] blocks_tbl [NUM_TABLE];
	for (genvar g = 0; g < NUM_TABLE; g++) begin : g_blk
		localparam int S = HEADER_BYTES + int'(CLASS_BYTES[g]);
		localparam int N = (PAGE_BYTES + S - 1) / S;
		localparam int B = (N > MAX_BLOCKS) ? MAX_BLOCKS : N;
		assign blocks_tbl[g] = HW_W'(B);
	end

	logic              req_q;
	logic [31:0]       size_q;
	logic [5:0]        cls_q;
	logic [11:0]       fblk_q;
	logic [NUM_CLASSES-1:0] ready_q;
	logic [2:0]        st_q;
	logic [5:0]        rcls_q;
	logic [11:0]       rblk_q;
	logic [16:0]       off_q;
	logic [17:0]       stride_q;

	logic [LINK_W-1:0] head_rd, link_rd, head_wd, head_eff;
	logic [HW_W-1:0]   hw_rd, hw_eff;
	logic              head_we, hw_we, link_we;
	logic [CLS_W-1:0]  cidx;
	logic              cls_ok, pg_ready;

	// search probe
	logic [5:0] mask, probe;
	assign mask  = 6'd1 << cmd.step_bit;
	assign probe = cls_q | (mask - 6'd1);

	assign cidx     = cls_q[CLS_W-1:0];
	assign cls_ok   = {1'b0, cls_q} < 7'(NUM_CLASSES);
	assign pg_ready = cls_ok && ready_q[cidx];
	assign head_eff = pg_ready ? head_rd : {1'b1, {BLK_W{1'b0}}};
	assign hw_eff   = pg_ready ? hw_rd : '0;

	// decision terms
	logic size_zero, size_big, head_empty, has_tail, free_bad;
	assign size_zero  = (size_q == 32'd0);
	assign size_big   = (size_q > 32'(PAGE_BYTES)) || !cls_ok;
	assign head_empty = head_eff[LINK_W-1];
	assign has_tail   = hw_eff < blocks_tbl[cls_q];
	assign free_bad   = !pg_ready || (13'(fblk_q) >= 13'(hw_eff));

	logic alloc_ok;
	assign alloc_ok = (req_q == REQ_ALLOC) && !size_zero && !size_big;
	assign stat.need_pop = alloc_ok && !head_empty;

	always_comb begin
		head_we = 1'b0;
		hw_we   = 1'b0;
		link_we = 1'b0;
		head_wd = link_rd;
		if (cmd.decide) begin
			if (req_q == REQ_FREE) begin
				if (!free_bad) begin
					link_we = 1'b1;
					head_we = 1'b1;
					head_wd = {1'b0, fblk_q[BLK_W-1:0]};
				end
			end else if (alloc_ok && head_empty && has_tail) begin
				hw_we   = 1'b1;
				head_we = !pg_ready;
				head_wd = {1'b1, {BLK_W{1'b0}}};
			end
		end else if (cmd.pop) begin
			head_we = 1'b1;
		end
	end

	scfa_ram #(.WIDTH(LINK_W), .DEPTH(NUM_CLASSES)) u_head (
		.clk(clk), .we(head_we), .waddr(cidx), .wdata(head_wd),
		.raddr(cidx), .rdata(head_rd)
	);

	scfa_ram #(.WIDTH(HW_W), .DEPTH(NUM_CLASSES)) u_hw (
		.clk(clk), .we(hw_we), .waddr(cidx), .wdata(HW_W'(hw_eff + 1'b1)),
		.raddr(cidx), .rdata(hw_rd)
	);

	scfa_ram #(.WIDTH(LINK_W), .DEPTH(LNK_D)) u_link (
		.clk(clk), .we(link_we),
		.waddr({cidx, fblk_q[BLK_W-1:0]}), .wdata(head_eff),
		.raddr({cidx, head_eff[BLK_W-1:0]}), .rdata(link_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= '0;
		end else if (hw_we) begin
			ready_q[cidx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q  <= req_type;
			size_q <= request_size;
			fblk_q <= free_block;
			cls_q  <= (req_type == REQ_FREE) ? free_class : 6'd0;
		end
		if (cmd.search && (req_q == REQ_ALLOC)) begin
			if ({15'd0, CLASS_BYTES[probe]} < size_q) begin
				cls_q <= cls_q | mask;
			end
		end
		if (cmd.decide) begin
			stride_q <= 18'(HEADER_BYTES) + 18'(CLASS_BYTES[cls_q]);
			if (req_q == REQ_FREE) begin
				st_q   <= free_bad ? ST_BADFREE : ST_OK;
				rcls_q <= cls_q;
				rblk_q <= fblk_q;
			end else if (size_zero) begin
				st_q   <= ST_ZERO;
				rcls_q <= 6'd0;
				rblk_q <= 12'd0;
			end else if (size_big) begin
				st_q   <= ST_LARGE;
				rcls_q <= 6'd0;
				rblk_q <= 12'd0;
			end else if (!head_empty) begin
				st_q   <= ST_OK;
				rcls_q <= cls_q;
				rblk_q <= 12'(head_eff[BLK_W-1:0]);
			end else if (has_tail) begin
				st_q   <= ST_OK;
				rcls_q <= cls_q;
				rblk_q <= 12'(hw_eff);
			end else begin
				st_q   <= ST_EXHAUSTED;
				rcls_q <= cls_q;
				rblk_q <= 12'd0;
			end
		end
		if (cmd.mul) begin
			off_q <= (st_q == ST_OK) ?
				17'(30'(rblk_q) * 30'(stride_q) + 30'(HEADER_BYTES)) : 17'd0;
		end
	end

	assign status         = st_q;
	assign granted_class  = rcls_q;
	assign granted_block  = rblk_q;
	assign payload_offset = off_q;

endmodule
`default_nettype wire
